/* rtl/crcbs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// crcbs_pkg: shared types and constants for the bit-serial CRC block
// Register indexes, queue sizing, job kinds and the job control record.
// ----------------------------------------------------------------------------
package crcbs_pkg;

	// Default largest polynomial degree
	localparam int MAX_DEGREE_DEF = 32;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int GEN_W      = 32;
	localparam int DEG_W      = 6;

	localparam logic [CFG_IDX_W-1:0] REG_CHECK_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GENERATOR  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEGREE     = 2'd2;

	localparam logic [GEN_W-1:0] GEN_RESET    = 32'd4129;
	localparam logic [DEG_W-1:0] DEGREE_RESET = 6'd16;

	// Bit counter saturates here
	localparam logic [DEG_W-1:0] BITS_SEEN_MAX = 6'd63;

	// Stream data widths (whole bytes)
	localparam int S_TDATA_W = 8;
	localparam int M_TDATA_W = 8;

	// Job queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = 2;

	// What the back end does with a job
	typedef enum logic [1:0] {
		JOB_ECHO      = 2'd0,
		JOB_ECHO_DUMP = 2'd1,
		JOB_VERDICT   = 2'd2
	} job_kind_t;

	typedef struct packed {
		job_kind_t kind;
		logic      msg_bit;
		logic      frame_ok;
		logic      frame_short;
	} job_ctl_t;

endpackage
`default_nettype wire

/* rtl/crcbs_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// crcbs_front: configuration registers and remainder update
// Takes one bit per request, runs one division step and queues a job (in check mode only at end of frame).
// ----------------------------------------------------------------------------
module crcbs_front #(
	parameter int MAX_DEGREE = crcbs_pkg::MAX_DEGREE_DEF
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	// configuration
	input  wire                                    cfg_we,
	input  wire  [crcbs_pkg::CFG_IDX_W-1:0]        cfg_idx,
	input  wire  [crcbs_pkg::CFG_DATA_W-1:0]       cfg_data,
	// input bits
	input  wire                                    in_valid,
	output logic                                   in_ready,
	input  wire                                    in_bit,
	input  wire                                    in_eof,
	// job push
	output logic                                   push,
	input  wire                                    q_full,
	output crcbs_pkg::job_ctl_t                    push_ctl,
	output logic [MAX_DEGREE-1:0]                  push_rem,
	output logic [$clog2(MAX_DEGREE+1)-1:0]        push_deg
);
	import crcbs_pkg::*;

	localparam int RW = MAX_DEGREE;
	localparam int DW = $clog2(MAX_DEGREE+1);

	logic             check_mode_q;
	logic [GEN_W-1:0] gen_q;
	logic [DEG_W-1:0] degree_q;
	logic [RW-1:0]    rem_q;
	logic [DEG_W-1:0] bits_q;

	logic [DW-1:0]    d_eff;
	logic [RW-1:0]    mask;
	logic [RW-1:0]    gen_m;
	logic [RW-1:0]    rem_m;
	logic [RW-1:0]    top_sh;
	logic             top;
	logic [RW-1:0]    rem_nx;
	logic [DEG_W-1:0] bits_nx;
	logic             is_short;
	logic             take;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_mode_q <= 1'b0;
			gen_q        <= GEN_RESET;
			degree_q     <= DEGREE_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_CHECK_MODE: check_mode_q <= cfg_data[0];
				REG_GENERATOR:  gen_q        <= cfg_data[GEN_W-1:0];
				REG_DEGREE:     degree_q     <= cfg_data[DEG_W-1:0];
				default: ;
			endcase
		end
	end

	// Degree clamped to 1..MAX_DEGREE
	always_comb begin
		if (degree_q == '0)
			d_eff = DW'(1);
		else if ({2'b00, degree_q} > 8'(RW))
			d_eff = DW'(RW);
		else
			d_eff = DW'(degree_q);
	end

	assign in_ready = !q_full;
	assign take     = in_valid && in_ready;

	// One division step
	always_comb begin
		mask    = ~({RW{1'b1}} << d_eff);
		gen_m   = RW'(gen_q) & mask;
		rem_m   = rem_q & mask;
		top_sh  = rem_m >> (d_eff - DW'(1));
		top     = top_sh[0];
		if (!check_mode_q)
			rem_nx = ((rem_m << 1) & mask) ^ ((top ^ in_bit) ? gen_m : '0);
		else
			rem_nx = ((rem_m << 1) | RW'(in_bit)) & mask ^ (top ? gen_m : '0);
		bits_nx  = (bits_q == BITS_SEEN_MAX) ? bits_q : bits_q + DEG_W'(1);
		is_short = 8'(bits_nx) < 8'(d_eff);
	end

	// State update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			bits_q <= '0;
		end else if (take) begin
			if (in_eof) begin
				rem_q  <= '0;
				bits_q <= '0;
			end else begin
				rem_q  <= rem_nx;
				bits_q <= bits_nx;
			end
		end
	end

	// Job classification
	always_comb begin
		push                 = take && (!check_mode_q || in_eof);
		push_ctl.msg_bit     = check_mode_q ? 1'b0 : in_bit;
		push_ctl.frame_ok    = check_mode_q && (rem_nx == '0) && !is_short;
		push_ctl.frame_short = check_mode_q && is_short;
		if (check_mode_q)
			push_ctl.kind = JOB_VERDICT;
		else if (in_eof)
			push_ctl.kind = JOB_ECHO_DUMP;
		else
			push_ctl.kind = JOB_ECHO;
		// remainder left-aligned so the back end shifts out the top bit
		push_rem = rem_nx << (DW'(RW) - d_eff);
		push_deg = d_eff;
	end

endmodule
`default_nettype wire

/* rtl/crcbs_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// crcbs_queue: short job queue
// Register-based FIFO between front and back; push and pop can occur in the same cycle.
// ----------------------------------------------------------------------------
module crcbs_queue #(
	parameter int W = 8
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          push,
	input  wire  [W-1:0] push_data,
	output logic         full,
	input  wire          pop,
	output logic         empty,
	output logic [W-1:0] head
);
	import crcbs_pkg::*;

	logic [W-1:0]           mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_q;
	logic [QUEUE_PTR_W-1:0] rd_q;
	logic [QUEUE_PTR_W:0]   cnt_q;

	assign full  = cnt_q == (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
	assign empty = cnt_q == '0;
	assign head  = mem_q[rd_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

	// Pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + QUEUE_PTR_W'(1);
			if (pop)
				rd_q <= rd_q + QUEUE_PTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + (QUEUE_PTR_W+1)'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - (QUEUE_PTR_W+1)'(1);
		end
	end

endmodule
`default_nettype wire

/* rtl/crcbs_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// crcbs_back: result sequencer
// Pops jobs, emits echo bits, shifts out remainders and verdicts.
// ----------------------------------------------------------------------------
module crcbs_back #(
	parameter int MAX_DEGREE = crcbs_pkg::MAX_DEGREE_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	// job pop
	input  wire                                q_empty,
	output logic                               pop,
	input  crcbs_pkg::job_ctl_t                head_ctl,
	input  wire  [MAX_DEGREE-1:0]              head_rem,
	input  wire  [$clog2(MAX_DEGREE+1)-1:0]    head_deg,
	// results
	output logic                               out_valid,
	input  wire                                out_ready,
	output logic                               out_bit,
	output logic                               out_last,
	output logic                               out_ok,
	output logic                               out_short
);
	import crcbs_pkg::*;

	localparam int RW = MAX_DEGREE;
	localparam int DW = $clog2(MAX_DEGREE+1);

	logic          valid_q;
	logic          bit_q;
	logic          last_q;
	logic          ok_q;
	logic          short_q;
	logic [RW-1:0] shf_q;
	logic [DW-1:0] cnt_q;
	logic          slot_free;

	assign slot_free = !valid_q || out_ready;
	assign pop       = slot_free && (cnt_q == '0) && !q_empty;

	assign out_valid = valid_q;
	assign out_bit   = bit_q;
	assign out_last  = last_q;
	assign out_ok    = ok_q;
	assign out_short = short_q;

	// Control: output valid and remainder bit count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cnt_q   <= '0;
		end else if (slot_free) begin
			if (cnt_q != '0) begin
				valid_q <= 1'b1;
				cnt_q   <= cnt_q - DW'(1);
			end else if (!q_empty) begin
				valid_q <= 1'b1;
				if (head_ctl.kind == JOB_ECHO_DUMP)
					cnt_q <= head_deg;
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	// Result payload and remainder shifter
	always_ff @(posedge clk) begin
		if (slot_free) begin
			if (cnt_q != '0) begin
				bit_q   <= shf_q[RW-1];
				last_q  <= cnt_q == DW'(1);
				ok_q    <= 1'b0;
				short_q <= 1'b0;
				shf_q   <= shf_q << 1;
			end else if (!q_empty) begin
				bit_q   <= head_ctl.msg_bit;
				last_q  <= head_ctl.kind == JOB_VERDICT;
				ok_q    <= head_ctl.frame_ok;
				short_q <= head_ctl.frame_short;
				shf_q   <= head_rem;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/crc_bit_serial_generate_check.sv */
`default_nettype none
// Bit-serial CRC generator / checker, one frame bit per request.
// Throughput: one input bit per cycle while the job queue is not full; in generate
// mode the degree remainder bits after a final bit are shifted out by the back end.
// An input request reaches its first result through the queue, then the output register.
// Reset (arst_n low): registers to generate mode, generator 0x1021, degree 16;
// remainder, bit counter, queue and output cleared.
// ----------------------------------------------------------------------------
// crc_bit_serial_generate_check: top level
// Front end divides, a job queue decouples it from the result sequencer.
// ----------------------------------------------------------------------------
module crc_bit_serial_generate_check #(
	parameter int MAX_DEGREE = crcbs_pkg::MAX_DEGREE_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// configuration write port
	input  wire                                 cfg_we,
	input  wire  [crcbs_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  wire  [crcbs_pkg::CFG_DATA_W-1:0]    cfg_data,
	// input stream
	input  wire                                 s_axis_tvalid,
	output logic                                s_axis_tready,
	input  wire  [crcbs_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // [0] msg_bit
	input  wire                                 s_axis_tlast,  // end_of_frame
	// result stream
	output logic                                m_axis_tvalid,
	input  wire                                 m_axis_tready,
	output logic [crcbs_pkg::M_TDATA_W-1:0]     m_axis_tdata,  // [0] out_bit, [1] frame_ok,
	                                                           // [2] frame_short
	output logic                                m_axis_tlast   // out_last
);
	import crcbs_pkg::*;

	localparam int RW = MAX_DEGREE;
	localparam int DW = $clog2(MAX_DEGREE+1);
	localparam int CW = $bits(job_ctl_t);
	localparam int QW = CW + RW + DW;

	logic          push;
	logic          q_full;
	logic          q_empty;
	logic          pop;
	job_ctl_t      push_ctl;
	logic [RW-1:0] push_rem;
	logic [DW-1:0] push_deg;
	logic [QW-1:0] q_head;
	job_ctl_t      head_ctl;
	logic          out_bit;
	logic          out_ok;
	logic          out_short;

	crcbs_front #(
		.MAX_DEGREE(MAX_DEGREE)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_bit   (s_axis_tdata[0]),
		.in_eof   (s_axis_tlast),
		.push     (push),
		.q_full   (q_full),
		.push_ctl (push_ctl),
		.push_rem (push_rem),
		.push_deg (push_deg)
	);

	crcbs_queue #(
		.W(QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_deg, push_rem, push_ctl}),
		.full      (q_full),
		.pop       (pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	assign head_ctl = job_ctl_t'(q_head[CW-1:0]);

	crcbs_back #(
		.MAX_DEGREE(MAX_DEGREE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.pop       (pop),
		.head_ctl  (head_ctl),
		.head_rem  (q_head[CW+RW-1:CW]),
		.head_deg  (q_head[QW-1:CW+RW]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_bit   (out_bit),
		.out_last  (m_axis_tlast),
		.out_ok    (out_ok),
		.out_short (out_short)
	);

	// Pack result fields, zero fill to a byte
	assign m_axis_tdata = {{(M_TDATA_W-3){1'b0}}, out_short, out_ok, out_bit};

endmodule
`default_nettype wire

/* test/tb_crc_bit_serial_generate_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_crc_bit_serial_generate_check: self-checking bench for the bit-serial CRC
// Streams frames one bit per request under random source gaps and sink stalls.
// A local division model predicts every echo, appended remainder bit and check
// verdict, and each result is compared in order against it.
// ----------------------------------------------------------------------------
module tb_crc_bit_serial_generate_check;
	import crcbs_pkg::*;

	localparam int MAX_DEG       = MAX_DEGREE_DEF;
	localparam int CLK_HALF      = 4;
	localparam int RESET_CYCLES  = 11;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_BITS   = 250;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int IDLE_PCT      = 33;
	// index with no register behind it; writes must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic out_bit;
		logic out_last;
		logic frame_ok;
		logic frame_short;
	} crc_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [S_TDATA_W-1:0]  s_axis_tdata;   // [0] msg_bit
	logic                  s_axis_tlast;   // end_of_frame
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [M_TDATA_W-1:0]  m_axis_tdata;   // [0] out_bit, [1] frame_ok, [2] frame_short
	logic                  m_axis_tlast;   // out_last

	// predictor copy of the registers and division state
	logic             mode_chk  = 1'b0;
	logic [31:0]      gen_low   = GEN_RESET;
	logic [DEG_W-1:0] deg_field = DEGREE_RESET;
	logic [31:0]      rem_state = '0;
	logic [DEG_W-1:0] bit_count = '0;

	crc_result_t pending_results[$];

	int fail_count   = 0;
	int cycles       = 0;
	int bits_sent    = 0;
	int frames_sent  = 0;
	int results_seen = 0;
	int verdict_ok   = 0;
	int verdict_bad  = 0;
	int verdict_shrt = 0;
	bit idling       = 1'b1;

	crc_bit_serial_generate_check dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// run-length guard
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_crc_bit_serial_generate_check NOT OK");
			$finish;
		end
	end

	// degree register clamped to 1..MAX_DEG
	function automatic int unsigned eff_degree();
		int unsigned d;
		d = 32'(deg_field);
		if (d < 1) d = 1;
		if (d > MAX_DEG) d = MAX_DEG;
		return d;
	endfunction

	function automatic logic [63:0] deg_mask(input int unsigned d);
		return (64'd1 << d) - 64'd1;
	endfunction

	// one accepted frame bit: advance the division, queue what it produces
	function automatic void divide_bit(input logic b, input logic eof);
		int unsigned d;
		int          i;
		logic [63:0] mask;
		logic [63:0] gen;
		logic [63:0] rem;
		logic        top;
		logic        short_f;
		d    = eff_degree();
		mask = deg_mask(d);
		gen  = {32'd0, gen_low} & mask;
		rem  = {32'd0, rem_state} & mask;
		top  = rem[d-1];
		if (bit_count != BITS_SEEN_MAX) bit_count++;
		if (!mode_chk) begin
			// message times x^d: new bit enters at the top
			rem = (rem << 1) & mask;
			if (top ^ b) rem ^= gen;
			pending_results.push_back('{b, 1'b0, 1'b0, 1'b0});
			if (eof) begin
				for (i = d - 1; i >= 0; i--)
					pending_results.push_back('{rem[i], logic'(i == 0), 1'b0, 1'b0});
			end
		end else begin
			// received frame divided as is
			rem = ((rem << 1) | {63'd0, b}) & mask;
			if (top) rem ^= gen;
			if (eof) begin
				short_f = bit_count < d;
				pending_results.push_back('{1'b0, 1'b1, logic'(rem == 0 && !short_f), short_f});
				if (short_f) verdict_shrt++;
				else if (rem == 0) verdict_ok++;
				else verdict_bad++;
			end
		end
		if (eof) begin
			rem_state = '0;
			bit_count = '0;
		end else begin
			rem_state = rem[31:0];
		end
	endfunction

	// append the remainder of frame * x^d so the frame divides evenly
	function automatic void append_crc(ref logic frame[$]);
		int unsigned d;
		int          i;
		logic [63:0] mask;
		logic [63:0] gen;
		logic [63:0] rem;
		logic        top;
		d    = eff_degree();
		mask = deg_mask(d);
		gen  = {32'd0, gen_low} & mask;
		rem  = '0;
		foreach (frame[k]) begin
			top = rem[d-1];
			rem = (rem << 1) & mask;
			if (top ^ frame[k]) rem ^= gen;
		end
		for (i = d - 1; i >= 0; i--) frame.push_back(rem[i]);
	endfunction

	function automatic void check_field(input string name, input logic want, input logic got);
		if (got !== want) begin
			$error("%s mismatch: expected %0b, got %0b", name, want, got);
			fail_count++;
		end
	endfunction

	// sink stalls
	always @(negedge clk)
		m_axis_tready <= !idling || ($urandom_range(99) >= IDLE_PCT);

	// compare each accepted result with the oldest prediction
	always @(posedge clk) begin : result_check
		crc_result_t got;
		crc_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = '{m_axis_tdata[0], m_axis_tlast, m_axis_tdata[1], m_axis_tdata[2]};
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("unexpected result: out_bit %0b out_last %0b frame_ok %0b frame_short %0b",
					got.out_bit, got.out_last, got.frame_ok, got.frame_short);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("out_bit", want.out_bit, got.out_bit);
				check_field("out_last", want.out_last, got.out_last);
				check_field("frame_ok", want.frame_ok, got.frame_ok);
				check_field("frame_short", want.frame_short, got.frame_short);
			end
		end
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_bit(input logic b, input logic eof);
		while (idling && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(S_TDATA_W-1){1'b0}}, b};
		s_axis_tlast  <= eof;
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
		divide_bit(b, eof);
		bits_sent++;
		@(negedge clk);
	endtask

	task automatic send_frame(input logic frame[$]);
		foreach (frame[k]) send_bit(frame[k], k == frame.size() - 1);
		frames_sent++;
	endtask

	// drop the request, let every result out, then give the block time to settle
	task automatic quiesce();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_CHECK_MODE: mode_chk  = data[0];
			REG_GENERATOR:  gen_low   = data;
			REG_DEGREE:     deg_field = data[DEG_W-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// generate mode with the power-on polynomial
	task automatic test_reset_defaults();
		send_frame('{1'b1, 1'b0, 1'b1});
		quiesce();
	endtask

	// smallest and largest degree, empty and full generators, clamped degrees
	task automatic test_generate_extremes();
		write_reg(REG_DEGREE, 32'd1);
		write_reg(REG_GENERATOR, 32'd1);
		send_frame('{1'b1});
		quiesce();
		write_reg(REG_DEGREE, 32'd0);
		send_frame('{1'b1, 1'b1});
		quiesce();
		write_reg(REG_GENERATOR, 32'hFFFF_FFFF);
		write_reg(REG_DEGREE, 32'd32);
		send_frame('{1'b1, 1'b0});
		quiesce();
		// upper data bits ignored: degree field reads 63, clamps to the maximum
		write_reg(REG_DEGREE, 32'hFFFF_FFFF);
		write_reg(REG_SPARE, 32'hFFFF_FFFF);
		write_reg(REG_GENERATOR, 32'd0);
		send_frame('{1'b1});
		quiesce();
	endtask

	// good codeword, corrupted codeword and a short frame
	task automatic test_check_verdicts();
		logic frame[$];
		write_reg(REG_CHECK_MODE, 32'd1);
		write_reg(REG_DEGREE, 32'd4);
		write_reg(REG_GENERATOR, 32'h3);
		frame = '{1'b1, 1'b1};
		append_crc(frame);
		send_frame(frame);
		frame[2] = ~frame[2];
		send_frame(frame);
		send_frame('{1'b1, 1'b0});
		quiesce();
	endtask

	// settings changed between bits of one frame
	task automatic test_midframe_config();
		send_bit(1'b1, 1'b0);
		send_bit(1'b0, 1'b1 == 1'b0);
		send_bit(1'b1, 1'b0);
		quiesce();
		write_reg(REG_DEGREE, 32'd3);
		send_bit(1'b1, 1'b0);
		send_bit(1'b0, 1'b1);
		quiesce();
		write_reg(REG_CHECK_MODE, 32'd0);
		send_bit(1'b1, 1'b0);
		send_bit(1'b1, 1'b0);
		quiesce();
		write_reg(REG_GENERATOR, 32'h5);
		send_bit(1'b0, 1'b1);
		frames_sent += 2;
		quiesce();
	endtask

	task automatic random_config();
		logic [31:0] data;
		int          pick;
		if ($urandom_range(1)) begin
			data = $urandom();
			write_reg(REG_CHECK_MODE, data);
		end
		if ($urandom_range(1)) write_reg(REG_GENERATOR, $urandom());
		if ($urandom_range(1)) begin
			data = $urandom();
			pick = $urandom_range(99);
			if (pick < 15) begin
				case ($urandom_range(4))
					0: data[DEG_W-1:0] = 6'd0;
					1: data[DEG_W-1:0] = 6'd1;
					2: data[DEG_W-1:0] = 6'd32;
					3: data[DEG_W-1:0] = 6'd33;
					default: data[DEG_W-1:0] = 6'd63;
				endcase
			end else if (pick < 75) begin
				data[DEG_W-1:0] = DEG_W'($urandom_range(12, 1));
			end else begin
				data[DEG_W-1:0] = DEG_W'($urandom_range(32, 1));
			end
			write_reg(REG_DEGREE, data);
		end
	endtask

	// phases of random settings; check mode mostly sees valid codewords
	task automatic test_random_traffic();
		logic frame[$];
		int   start;
		int   len;
		int   kind;
		int   n_frames;
		start = bits_sent;
		while (bits_sent < start + RANDOM_BITS) begin
			// one long stretch with neither side idling
			idling = !(bits_sent - start >= 100 && bits_sent - start < 180);
			random_config();
			n_frames = $urandom_range(4, 1);
			repeat (n_frames) begin
				frame.delete();
				kind = $urandom_range(99);
				if (!mode_chk) begin
					len = (kind < 10) ? $urandom_range(80, 50) : $urandom_range(20, 1);
					repeat (len) frame.push_back(1'($urandom_range(1)));
				end else if (kind < 80) begin
					len = ($urandom_range(9) == 0) ? $urandom_range(48, 30) : $urandom_range(16, 0);
					repeat (len) frame.push_back(1'($urandom_range(1)));
					append_crc(frame);
					// some codewords get one bit flipped
					if (kind >= 65) begin
						len = $urandom_range(frame.size() - 1);
						frame[len] = ~frame[len];
					end
				end else begin
					len = $urandom_range(40, 1);
					repeat (len) frame.push_back(1'($urandom_range(1)));
				end
				send_frame(frame);
			end
			quiesce();
		end
		idling = 1'b1;
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_idx       = '0;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		m_axis_tready = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_generate_extremes();
		test_check_verdicts();
		test_midframe_config();
		test_random_traffic();
		quiesce();

		$display("Sent %0d bits in %0d frames; %0d results compared.",
			bits_sent, frames_sent, results_seen);
		$display("Check verdicts: %0d clean, %0d corrupt, %0d short.",
			verdict_ok, verdict_bad, verdict_shrt);
		if (fail_count == 0 && pending_results.size() == 0) begin
			$display("tb_crc_bit_serial_generate_check OK");
		end else begin
			$display("tb_crc_bit_serial_generate_check NOT OK");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/crcbs_pkg.sv
rtl/crcbs_front.sv
rtl/crcbs_queue.sv
rtl/crcbs_back.sv
rtl/crc_bit_serial_generate_check.sv
test/tb_crc_bit_serial_generate_check.sv
